FILE: rtl/modbus_rtu_master_framer_defines.svh
// ----------------------------------------------------------------------------
// modbus rtu master framer assertion macros
// shared checks, sampled on clk_i
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_MASTER_FRAMER_DEFINES_SVH
`define MODBUS_RTU_MASTER_FRAMER_DEFINES_SVH

// checked only while out of reset
`define MRMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset too
`define MRMF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/mrmf_pkg.sv
// ----------------------------------------------------------------------------
// mrmf_pkg
// types, codes and limits shared by the modbus rtu master framer
// ----------------------------------------------------------------------------
package mrmf_pkg;

  localparam int unsigned MAX_READ_WORDS  = 32;
  localparam int unsigned MAX_WRITE_WORDS = 123;
  localparam int unsigned WIDX_W          = $clog2(MAX_READ_WORDS);
  localparam int unsigned WCNT_W          = $clog2(MAX_READ_WORDS + 1);
  localparam int unsigned LEFT_W          = $clog2(MAX_WRITE_WORDS + 1);
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned TX_MAX_BYTES    = 7;
  localparam int unsigned TX_IDX_W        = $clog2(TX_MAX_BYTES);
  localparam int unsigned TX_LEN_W        = $clog2(TX_MAX_BYTES + 1);
  localparam int unsigned STEP_W          = $clog2(TX_MAX_BYTES + 3);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_WRITE_MULTI  = 8'h10;

  localparam logic [7:0] RX_CNT_MAX      = 8'hFF;
  localparam logic [7:0] WRITE_RESP_LEN  = 8'd8;
  localparam logic [7:0] READ_RESP_EXTRA = 8'd5;
  localparam logic [7:0] DATA_OFFSET     = 8'd3;

  typedef enum logic [2:0] {
    REQ_READ         = 3'd0,
    REQ_WRITE_SINGLE = 3'd1,
    REQ_WRITE_MULTI  = 3'd2,
    REQ_DATA_WORD    = 3'd3,
    REQ_RX_BYTE      = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_STATUS = 2'd2
  } out_kind_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_LEN   = 3'd1,
    ST_CRC   = 3'd2,
    ST_UNEXP = 3'd3,
    ST_RANGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_TX   = 2'd0,
    CMD_STAT = 2'd1,
    CMD_RX   = 2'd2
  } cmd_op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  slave_id;
    logic [15:0] reg_addr;
    logic [15:0] count_or_value;
    logic [15:0] data_word;
    logic [7:0]  rx_byte;
    logic        rx_end;
  } req_t;

  typedef struct packed {
    cmd_op_e                          op;
    logic [TX_MAX_BYTES-1:0][7:0]     bytes;
    logic [TX_LEN_W-1:0]              tx_len;
    logic                             crc_init;
    logic                             crc_tail;
    status_e                          code;
    logic                             rx_store;
    logic                             rx_odd;
    logic [WIDX_W-1:0]                rx_widx;
    logic                             rx_end;
    logic                             rx_len_ok;
    logic [WCNT_W-1:0]                rx_wcnt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [2:0]  status;
    logic        last;
  } res_t;

endpackage

FILE: rtl/mrmf_req_if.sv
// ----------------------------------------------------------------------------
// mrmf_req_if
// request channel: valid, ready and one request item
// ----------------------------------------------------------------------------
interface mrmf_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  slave_id;
  logic [15:0] reg_addr;
  logic [15:0] count_or_value;
  logic [15:0] data_word;
  logic [7:0]  rx_byte;
  logic        rx_end;

  modport source (
    output valid, req_type, slave_id, reg_addr, count_or_value, data_word, rx_byte, rx_end,
    input  ready
  );
  modport sink (
    input  valid, req_type, slave_id, reg_addr, count_or_value, data_word, rx_byte, rx_end,
    output ready
  );
endinterface

FILE: rtl/mrmf_res_if.sv
// ----------------------------------------------------------------------------
// mrmf_res_if
// result channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface mrmf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [15:0] out_value;
  logic [2:0]  status_code;
  logic        out_last;

  modport source (
    output valid, out_kind, out_value, status_code, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_value, status_code, out_last,
    output ready
  );
endinterface

FILE: rtl/mrmf_queue.sv
// ----------------------------------------------------------------------------
// mrmf_queue
// small command queue between the request front end and the frame engine
// ----------------------------------------------------------------------------
module mrmf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrmf_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output mrmf_pkg::cmd_t  cmd_o,
  output mrmf_pkg::q_stat_t q_stat_o
);
  import mrmf_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign q_stat_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !q_stat_o.full;
  assign do_pop  = pop_i && !q_stat_o.empty;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/mrmf_front.sv
// ----------------------------------------------------------------------------
// mrmf_front
// accepts request items, tracks the pending transaction and turns each item
// into one command for the frame engine
// ----------------------------------------------------------------------------
module mrmf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mrmf_pkg::req_t    req_i,
  input  mrmf_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output mrmf_pkg::cmd_t    cmd_o
);
  import mrmf_pkg::*;

  typedef enum logic [1:0] {
    PK_IDLE  = 2'd0,
    PK_READ  = 2'd1,
    PK_WRITE = 2'd2,
    PK_WORDS = 2'd3
  } pend_e;

  pend_e             pend_q, pend_d;
  logic [WCNT_W-1:0] wcnt_q, wcnt_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic [7:0]        rxcnt_q, rxcnt_d;

  logic       accept;
  logic       is_read;
  logic [7:0] rx_off;
  logic [6:0] rx_w;
  logic [7:0] rxcnt_inc;
  logic [7:0] exp_len;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  assign is_read   = (pend_q == PK_READ);
  assign rx_off    = rxcnt_q - DATA_OFFSET;
  assign rx_w      = rx_off[7:1];
  assign rxcnt_inc = (rxcnt_q == RX_CNT_MAX) ? rxcnt_q : rxcnt_q + 8'd1;
  assign exp_len   = is_read ? 8'({wcnt_q, 1'b0}) + READ_RESP_EXTRA : WRITE_RESP_LEN;

  always_comb begin
    pend_d  = pend_q;
    wcnt_d  = wcnt_q;
    left_d  = left_q;
    rxcnt_d = rxcnt_q;
    cmd_o   = '0;
    cmd_o.op   = CMD_STAT;
    cmd_o.code = ST_UNEXP;
    if (accept) begin
      unique case (req_i.req_type)
        REQ_READ, REQ_WRITE_SINGLE: begin
          if (req_i.req_type == REQ_READ &&
              (req_i.count_or_value == '0 ||
               req_i.count_or_value > 16'(MAX_READ_WORDS))) begin
            pend_d     = PK_IDLE;
            cmd_o.code = ST_RANGE;
          end else begin
            cmd_o.op       = CMD_TX;
            cmd_o.bytes[0] = req_i.slave_id;
            cmd_o.bytes[1] = (req_i.req_type == REQ_READ) ? FUNC_READ_INPUT
                                                          : FUNC_WRITE_SINGLE;
            cmd_o.bytes[2] = req_i.reg_addr[15:8];
            cmd_o.bytes[3] = req_i.reg_addr[7:0];
            cmd_o.bytes[4] = req_i.count_or_value[15:8];
            cmd_o.bytes[5] = req_i.count_or_value[7:0];
            cmd_o.tx_len   = TX_LEN_W'(6);
            cmd_o.crc_init = 1'b1;
            cmd_o.crc_tail = 1'b1;
            rxcnt_d        = '0;
            if (req_i.req_type == REQ_READ) begin
              wcnt_d = req_i.count_or_value[WCNT_W-1:0];
              pend_d = PK_READ;
            end else begin
              pend_d = PK_WRITE;
            end
          end
        end
        REQ_WRITE_MULTI: begin
          if (req_i.count_or_value == '0 ||
              req_i.count_or_value > 16'(MAX_WRITE_WORDS)) begin
            pend_d     = PK_IDLE;
            cmd_o.code = ST_RANGE;
          end else begin
            cmd_o.op       = CMD_TX;
            cmd_o.bytes[0] = req_i.slave_id;
            cmd_o.bytes[1] = FUNC_WRITE_MULTI;
            cmd_o.bytes[2] = req_i.reg_addr[15:8];
            cmd_o.bytes[3] = req_i.reg_addr[7:0];
            cmd_o.bytes[4] = req_i.count_or_value[15:8];
            cmd_o.bytes[5] = req_i.count_or_value[7:0];
            cmd_o.bytes[6] = {req_i.count_or_value[6:0], 1'b0};
            cmd_o.tx_len   = TX_LEN_W'(7);
            cmd_o.crc_init = 1'b1;
            left_d         = req_i.count_or_value[LEFT_W-1:0];
            pend_d         = PK_WORDS;
          end
        end
        REQ_DATA_WORD: begin
          if (pend_q == PK_WORDS && left_q != '0) begin
            cmd_o.op       = CMD_TX;
            cmd_o.bytes[0] = req_i.data_word[15:8];
            cmd_o.bytes[1] = req_i.data_word[7:0];
            cmd_o.tx_len   = TX_LEN_W'(2);
            cmd_o.crc_tail = (left_q == LEFT_W'(1));
            left_d         = left_q - LEFT_W'(1);
            if (left_q == LEFT_W'(1)) begin
              pend_d  = PK_WRITE;
              rxcnt_d = '0;
            end
          end
        end
        REQ_RX_BYTE: begin
          if (pend_q == PK_READ || pend_q == PK_WRITE) begin
            cmd_o.op        = CMD_RX;
            cmd_o.bytes[0]  = req_i.rx_byte;
            cmd_o.rx_store  = is_read && (rxcnt_q >= DATA_OFFSET) && (rx_w < 7'(wcnt_q));
            cmd_o.rx_odd    = rx_off[0];
            cmd_o.rx_widx   = rx_w[WIDX_W-1:0];
            cmd_o.rx_end    = req_i.rx_end;
            cmd_o.rx_len_ok = (rxcnt_inc == exp_len);
            cmd_o.rx_wcnt   = is_read ? wcnt_q : '0;
            if (req_i.rx_end) begin
              pend_d  = PK_IDLE;
              rxcnt_d = '0;
            end else begin
              rxcnt_d = rxcnt_inc;
            end
          end
        end
        default: begin
          cmd_o.code = ST_UNEXP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= PK_IDLE;
      wcnt_q  <= '0;
      left_q  <= '0;
      rxcnt_q <= '0;
    end else begin
      pend_q  <= pend_d;
      wcnt_q  <= wcnt_d;
      left_q  <= left_d;
      rxcnt_q <= rxcnt_d;
    end
  end

endmodule

FILE: rtl/mrmf_back.sv
// ----------------------------------------------------------------------------
// mrmf_back
// frame engine: sends frame bytes with the running crc, checks responses,
// buffers read words and drains them after a good check
// ----------------------------------------------------------------------------
module mrmf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrmf_pkg::q_stat_t q_stat_i,
  input  mrmf_pkg::cmd_t    cmd_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mrmf_pkg::res_t    res_o
);
  import mrmf_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE,
    B_TX,
    B_STAT,
    B_RX,
    B_CHECK,
    B_WORD
  } bstate_e;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  bstate_e           state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [15:0]       crc_q, crc_d;
  status_e           code_q, code_d;
  logic [WCNT_W-1:0] ptr_q, ptr_d;
  logic              valid_q, valid_d;
  res_t              res_q, res_d;

  logic [15:0] mem [MAX_READ_WORDS];
  logic [15:0] rdata_q;
  logic [7:0]  held_q;
  logic        mem_we;
  logic        held_we;
  logic        out_free;
  logic [7:0]  tx_byte;

  assign out_free    = !valid_q || out_ready_i;
  assign tx_byte     = cmd_q.bytes[step_q[TX_IDX_W-1:0]];
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    step_d  = step_q;
    crc_d   = crc_q;
    code_d  = code_q;
    ptr_d   = ptr_q;
    valid_d = valid_q && !out_ready_i;
    res_d   = res_q;
    pop_o   = 1'b0;
    mem_we  = 1'b0;
    held_we = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o  = 1'b1;
          cmd_d  = cmd_i;
          step_d = '0;
          case (cmd_i.op)
            CMD_TX: begin
              if (cmd_i.crc_init) begin
                crc_d = CRC_INIT;
              end
              state_d = B_TX;
            end
            CMD_RX: begin
              state_d = B_RX;
            end
            default: begin
              code_d  = cmd_i.code;
              state_d = B_STAT;
            end
          endcase
        end
      end
      B_TX: begin
        if (out_free) begin
          valid_d      = 1'b1;
          res_d.kind   = KIND_TX;
          res_d.status = ST_OK;
          if (step_q < STEP_W'(cmd_q.tx_len)) begin
            res_d.value = {8'h00, tx_byte};
            crc_d       = crc_feed(crc_q, tx_byte);
            res_d.last  = !cmd_q.crc_tail && (step_q + STEP_W'(1) == STEP_W'(cmd_q.tx_len));
          end else if (step_q == STEP_W'(cmd_q.tx_len)) begin
            res_d.value = {8'h00, crc_q[7:0]};
            res_d.last  = 1'b0;
          end else begin
            res_d.value = {8'h00, crc_q[15:8]};
            res_d.last  = 1'b1;
            crc_d       = CRC_INIT;
          end
          step_d = step_q + STEP_W'(1);
          if (res_d.last) begin
            state_d = B_IDLE;
          end
        end
      end
      B_STAT: begin
        if (out_free) begin
          valid_d      = 1'b1;
          res_d.kind   = KIND_STATUS;
          res_d.value  = 16'(code_q);
          res_d.status = code_q;
          res_d.last   = 1'b1;
          state_d      = B_IDLE;
        end
      end
      B_RX: begin
        crc_d = crc_feed(crc_q, cmd_q.bytes[0]);
        if (cmd_q.rx_store) begin
          mem_we  = cmd_q.rx_odd;
          held_we = !cmd_q.rx_odd;
        end
        state_d = cmd_q.rx_end ? B_CHECK : B_IDLE;
      end
      B_CHECK: begin
        crc_d = CRC_INIT;
        ptr_d = '0;
        if (!cmd_q.rx_len_ok) begin
          code_d  = ST_LEN;
          state_d = B_STAT;
        end else if (crc_q != '0) begin
          code_d  = ST_CRC;
          state_d = B_STAT;
        end else begin
          code_d  = ST_OK;
          state_d = (cmd_q.rx_wcnt != '0) ? B_WORD : B_STAT;
        end
      end
      B_WORD: begin
        if (out_free) begin
          valid_d      = 1'b1;
          res_d.kind   = KIND_WORD;
          res_d.value  = rdata_q;
          res_d.status = ST_OK;
          res_d.last   = 1'b0;
          ptr_d        = ptr_q + WCNT_W'(1);
          if (ptr_q + WCNT_W'(1) == cmd_q.rx_wcnt) begin
            state_d = B_STAT;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cmd_q   <= '0;
      step_q  <= '0;
      crc_q   <= CRC_INIT;
      code_q  <= ST_OK;
      ptr_q   <= '0;
      valid_q <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      crc_q   <= crc_d;
      code_q  <= code_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
      res_q   <= res_d;
    end
  end

  // word buffer, registered read addressed by the next drain pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_q.rx_widx] <= {held_q, cmd_q.bytes[0]};
    end
    if (held_we) begin
      held_q <= cmd_q.bytes[0];
    end
    rdata_q <= mem[ptr_d[WIDX_W-1:0]];
  end

endmodule

FILE: rtl/modbus_rtu_master_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_master_framer
// modbus rtu master: builds request frames with crc-16 and checks responses
// ----------------------------------------------------------------------------
// Usage: request items arrive on req_i, result items leave on res_o, both
// valid/ready channels. Request types: read input registers and write single
// register give 8 transmit bytes; write multiple gives a 7 byte header, then
// 2 bytes per data word and the crc after the last word; response bytes give
// nothing until the byte marked rx_end, which gives the buffered read words
// (after a good check) and one status item.
// Each request item is classified combinationally and queued (4 deep), so
// req_i.ready only drops while the queue is full. The frame engine takes a
// command while idle, then sends its results; response bytes feed the crc
// and the closing byte also has length and crc checked. The buffered words
// drain at one per cycle unless res_o stalls, via a registered read of the
// word buffer. A stalled res_o holds its item; the engine waits and requests
// keep being taken until the queue fills. Reset returns to idle with an
// empty queue and no result pending; the word buffer is not cleared.
// ----------------------------------------------------------------------------
`include "modbus_rtu_master_framer_defines.svh"

module modbus_rtu_master_framer (
  input logic       clk_i,
  input logic       rst_ni,
  mrmf_req_if.sink  req_i,
  mrmf_res_if.source res_o
);
  import mrmf_pkg::*;

  req_t    req_s;
  cmd_t    front_cmd;
  cmd_t    queue_cmd;
  q_stat_t q_stat;
  res_t    res_s;
  logic    push;
  logic    pop;
  logic    in_ready;
  logic    out_valid;

  assign req_s.req_type       = req_i.req_type;
  assign req_s.slave_id       = req_i.slave_id;
  assign req_s.reg_addr       = req_i.reg_addr;
  assign req_s.count_or_value = req_i.count_or_value;
  assign req_s.data_word      = req_i.data_word;
  assign req_s.rx_byte        = req_i.rx_byte;
  assign req_s.rx_end         = req_i.rx_end;
  assign req_i.ready          = in_ready;

  mrmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .req_i      (req_s),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  mrmf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (queue_cmd),
    .q_stat_o (q_stat)
  );

  mrmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .res_o       (res_s)
  );

  assign res_o.valid       = out_valid;
  assign res_o.out_kind    = res_s.kind;
  assign res_o.out_value   = res_s.value;
  assign res_o.status_code = res_s.status;
  assign res_o.out_last    = res_s.last;

  `MRMF_ASSERT_RST(a_reset_no_result, !rst_ni |=> !res_o.valid, "result valid after reset")
  `MRMF_ASSERT(a_status_closes, res_o.valid && res_o.out_kind == KIND_STATUS |-> res_o.out_last && res_o.out_value == 16'(res_o.status_code), "status item malformed")
  `MRMF_ASSERT(a_data_status_zero, res_o.valid && res_o.out_kind != KIND_STATUS |-> res_o.status_code == ST_OK, "status code set on data item")
  `MRMF_ASSERT(a_pop_not_empty, pop |-> !q_stat.empty, "command taken from empty queue")
  `MRMF_ASSERT(a_full_stalls, q_stat.full |-> !req_i.ready, "request taken while queue full")

endmodule
